@@ rtl/hcrp_pkg.sv @@
// Package for the HTTP CONNECT reply parser.
// Holds field widths, protocol constants, item codes and the structs shared by the modules.
// Depends on nothing; every other file refers to it by scoped names.
package hcrp_pkg;

   // Field widths.
   localparam int unsigned KindWidth    = 2;
   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned OutcomeWidth = 3;
   localparam int unsigned StatusWidth  = 10;
   localparam int unsigned CountWidth   = 14;
   localparam int unsigned TailWidth    = 32;
   localparam int unsigned PrefixLen    = 5;

   // Protocol constants.
   localparam logic [CountWidth-1:0]  LIMIT_CAP     = 14'd8192;
   localparam logic [CountWidth-1:0]  MIN_REPLY     = 14'd12;
   localparam logic [CountWidth-1:0]  TAIL_MIN      = 14'd4;
   localparam logic [TailWidth-1:0]   TERMINATOR    = 32'h0D0A_0D0A;
   localparam logic [StatusWidth-1:0] STATUS_SAT    = 10'd1000;
   localparam logic [StatusWidth-1:0] STATUS_OK_LO  = 10'd200;
   localparam logic [StatusWidth-1:0] STATUS_OK_HI  = 10'd299;
   localparam logic [StatusWidth-1:0] STATUS_AUTH   = 10'd407;
   localparam logic [ByteWidth-1:0]   CHAR_SPACE    = 8'h20;
   localparam logic [ByteWidth-1:0]   CHAR_ZERO     = 8'h30;
   localparam logic [ByteWidth-1:0]   CHAR_NINE     = 8'h39;

   // Expected reply prefix "HTTP/".
   localparam logic [ByteWidth-1:0] PREFIX_TEXT [PrefixLen] =
      '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F};

   // Input item kinds.
   typedef enum logic [KindWidth-1:0] {
      KIND_START = 2'd0,
      KIND_BYTE  = 2'd1,
      KIND_CLOSE = 2'd2
   } kind_type;

   // Result outcomes.
   typedef enum logic [OutcomeWidth-1:0] {
      OUT_ACCEPTED  = 3'd0,
      OUT_AUTH      = 3'd1,
      OUT_REFUSED   = 3'd2,
      OUT_MALFORMED = 3'd3,
      OUT_TOO_LARGE = 3'd4,
      OUT_CLOSED    = 3'd5
   } outcome_type;

   // An item held in the input register.
   typedef struct packed {
      logic                 valid;
      logic [KindWidth-1:0] kind;
      logic [ByteWidth-1:0] rx_byte;
   } item_type;

   // A result produced by the scanner.
   typedef struct packed {
      logic                   valid;
      outcome_type            outcome;
      logic [StatusWidth-1:0] status_code;
      logic [CountWidth-1:0]  header_bytes;
   } result_type;

endpackage

@@ rtl/hcrp_req_if.sv @@
// Input channel of the HTTP CONNECT reply parser: one reply byte or control item.
// Depends on hcrp_pkg for field widths.
interface hcrp_req_if;
   logic                          valid;
   logic                          ready;
   logic [hcrp_pkg::KindWidth-1:0] kind;
   logic [hcrp_pkg::ByteWidth-1:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

@@ rtl/hcrp_rsp_if.sv @@
// Result channel of the HTTP CONNECT reply parser: one verdict item.
// Depends on hcrp_pkg for field widths.
interface hcrp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [hcrp_pkg::OutcomeWidth-1:0] outcome;
   logic [hcrp_pkg::StatusWidth-1:0]  status_code;
   logic [hcrp_pkg::CountWidth-1:0]   header_bytes;

   modport source (output valid, output outcome, output status_code, output header_bytes,
                   input ready);
   modport sink   (input valid, input outcome, input status_code, input header_bytes,
                   output ready);
endinterface

@@ rtl/hcrp_csr_if.sv @@
// Configuration write channel of the HTTP CONNECT reply parser (header limit).
// Depends on hcrp_pkg for the register width.
interface hcrp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [hcrp_pkg::CountWidth-1:0] header_limit;

   modport source (output valid, output header_limit, input ready);
   modport sink   (input valid, input header_limit, output ready);
endinterface

@@ rtl/hcrp_in_stage.sv @@
// Input register of the HTTP CONNECT reply parser.
// Depends on hcrp_pkg and hcrp_req_if.
module hcrp_in_stage (
   input  logic               clock,
   input  logic               reset,
   hcrp_req_if.sink           req_ch,
   input  logic               room,
   output hcrp_pkg::item_type item
);

   logic                          valid_ff, valid_in;
   logic [hcrp_pkg::KindWidth-1:0] kind_ff;
   logic [hcrp_pkg::ByteWidth-1:0] byte_ff;
   logic                          take;

   // The register empties whenever the scanner may consume, so a new item
   // can enter in every cycle that the result side is not stalled.
   assign req_ch.ready = !valid_ff || room;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (room) begin
         valid_in = 1'b0;
      end
   end

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff <= req_ch.kind;
         byte_ff <= req_ch.rx_byte;
      end
   end

   assign item.valid   = valid_ff;
   assign item.kind    = kind_ff;
   assign item.rx_byte = byte_ff;

endmodule

@@ rtl/hcrp_scan.sv @@
// Parse state and verdict logic of the HTTP CONNECT reply parser.
// Holds the header limit register; depends on hcrp_pkg and hcrp_csr_if.
module hcrp_scan (
   input  logic                 clock,
   input  logic                 reset,
   hcrp_csr_if.sink             csr_ch,
   input  hcrp_pkg::item_type   item,
   input  logic                 room,
   output hcrp_pkg::result_type result
);

   logic [hcrp_pkg::CountWidth-1:0]  limit_ff;
   logic [hcrp_pkg::CountWidth-1:0]  count_ff, count_in;
   logic [hcrp_pkg::TailWidth-1:0]   tail_ff, tail_in;
   logic                             prefix_ff, prefix_in;
   logic                             space_ff, space_in;
   logic [hcrp_pkg::CountWidth-1:0]  space_pos_ff, space_pos_in;
   logic                             first_digit_ff, first_digit_in;
   logic                             run_ff, run_in;
   logic [hcrp_pkg::StatusWidth-1:0] status_ff, status_in;
   logic                             verdict_ff, verdict_in;
   logic                             consume;

   assign csr_ch.ready = 1'b1;
   assign consume      = item.valid && room;

   // Header limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= hcrp_pkg::LIMIT_CAP;
      end else if (csr_ch.valid) begin
         limit_ff <= csr_ch.header_limit;
      end
   end

   // Next parse state and the result for the item being consumed.
   always_comb begin
      logic                            is_digit;
      logic [hcrp_pkg::CountWidth-1:0] ext;
      logic [hcrp_pkg::CountWidth-1:0] acc;
      logic [hcrp_pkg::CountWidth-1:0] limit_eff;
      logic [hcrp_pkg::CountWidth:0]   after_space;
      logic [hcrp_pkg::CountWidth:0]   space_end;
      logic [hcrp_pkg::StatusWidth-1:0] digit_sum;

      count_in       = count_ff;
      tail_in        = tail_ff;
      prefix_in      = prefix_ff;
      space_in       = space_ff;
      space_pos_in   = space_pos_ff;
      first_digit_in = first_digit_ff;
      run_in         = run_ff;
      status_in      = status_ff;
      verdict_in     = verdict_ff;
      result         = '0;

      // Status accumulator: value times ten plus the digit, saturated.
      is_digit  = (item.rx_byte >= hcrp_pkg::CHAR_ZERO) && (item.rx_byte <= hcrp_pkg::CHAR_NINE);
      ext       = {4'b0000, status_ff};
      acc       = (ext << 3) + (ext << 1) + {10'b0, item.rx_byte[3:0]};
      digit_sum = (acc > {4'b0000, hcrp_pkg::STATUS_SAT}) ? hcrp_pkg::STATUS_SAT
                                                          : acc[hcrp_pkg::StatusWidth-1:0];
      after_space = {1'b0, space_pos_ff} + 15'd1;
      limit_eff   = (limit_ff > hcrp_pkg::LIMIT_CAP) ? hcrp_pkg::LIMIT_CAP : limit_ff;
      space_end   = 15'd0;

      if (consume) begin
         case (item.kind)
            hcrp_pkg::KIND_START: begin
               count_in       = '0;
               tail_in        = '0;
               prefix_in      = 1'b1;
               space_in       = 1'b0;
               space_pos_in   = '0;
               first_digit_in = 1'b0;
               run_in         = 1'b0;
               status_in      = '0;
               verdict_in     = 1'b0;
            end
            hcrp_pkg::KIND_CLOSE: begin
               if (!verdict_ff) begin
                  result.valid        = 1'b1;
                  result.outcome      = hcrp_pkg::OUT_CLOSED;
                  result.status_code  = status_ff;
                  result.header_bytes = count_ff;
                  verdict_in          = 1'b1;
               end
            end
            hcrp_pkg::KIND_BYTE: begin
               if (!verdict_ff) begin
                  // Prefix check over the first five bytes.
                  if (count_ff < 14'd5 &&
                      item.rx_byte != hcrp_pkg::PREFIX_TEXT[count_ff[2:0]]) begin
                     prefix_in = 1'b0;
                  end
                  // Status digits after the first space.
                  if (space_ff) begin
                     if ({1'b0, count_ff} == after_space) begin
                        if (is_digit) begin
                           first_digit_in = 1'b1;
                           run_in         = 1'b1;
                           status_in      = digit_sum;
                        end else begin
                           run_in = 1'b0;
                        end
                     end else if (run_ff) begin
                        if (is_digit) begin
                           status_in = digit_sum;
                        end else begin
                           run_in = 1'b0;
                        end
                     end
                  end else if (item.rx_byte == hcrp_pkg::CHAR_SPACE) begin
                     space_in     = 1'b1;
                     space_pos_in = count_ff;
                  end
                  count_in  = count_ff + 14'd1;
                  tail_in   = {tail_ff[hcrp_pkg::TailWidth-9:0], item.rx_byte};
                  space_end = {1'b0, space_pos_in} + 15'd4;

                  // Verdict: limit first, then the header terminator.
                  if (count_in > limit_eff) begin
                     result.valid   = 1'b1;
                     result.outcome = hcrp_pkg::OUT_TOO_LARGE;
                  end else if (count_in >= hcrp_pkg::TAIL_MIN &&
                               tail_in == hcrp_pkg::TERMINATOR) begin
                     result.valid = 1'b1;
                     if (count_in < hcrp_pkg::MIN_REPLY || !prefix_in || !space_in ||
                         space_end > {1'b0, count_in} || !first_digit_in) begin
                        result.outcome = hcrp_pkg::OUT_MALFORMED;
                     end else if (status_in >= hcrp_pkg::STATUS_OK_LO &&
                                  status_in <= hcrp_pkg::STATUS_OK_HI) begin
                        result.outcome = hcrp_pkg::OUT_ACCEPTED;
                     end else if (status_in == hcrp_pkg::STATUS_AUTH) begin
                        result.outcome = hcrp_pkg::OUT_AUTH;
                     end else begin
                        result.outcome = hcrp_pkg::OUT_REFUSED;
                     end
                  end
                  if (result.valid) begin
                     result.status_code  = status_in;
                     result.header_bytes = count_in;
                     verdict_in          = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         tail_ff        <= '0;
         prefix_ff      <= 1'b1;
         space_ff       <= 1'b0;
         space_pos_ff   <= '0;
         first_digit_ff <= 1'b0;
         run_ff         <= 1'b0;
         status_ff      <= '0;
         verdict_ff     <= 1'b0;
      end else begin
         count_ff       <= count_in;
         tail_ff        <= tail_in;
         prefix_ff      <= prefix_in;
         space_ff       <= space_in;
         space_pos_ff   <= space_pos_in;
         first_digit_ff <= first_digit_in;
         run_ff         <= run_in;
         status_ff      <= status_in;
         verdict_ff     <= verdict_in;
      end
   end

endmodule

@@ rtl/hcrp_out_stage.sv @@
// Result register of the HTTP CONNECT reply parser.
// Depends on hcrp_pkg and hcrp_rsp_if.
module hcrp_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  hcrp_pkg::result_type result,
   output logic                 room,
   hcrp_rsp_if.source           rsp_ch
);

   logic                                valid_ff;
   hcrp_pkg::outcome_type               outcome_ff;
   logic [hcrp_pkg::StatusWidth-1:0]    status_ff;
   logic [hcrp_pkg::CountWidth-1:0]     bytes_ff;

   // The register can load when empty or when its item leaves this cycle.
   assign room = !valid_ff || rsp_ch.ready;

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (room) begin
         valid_ff <= result.valid;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (room && result.valid) begin
         outcome_ff <= result.outcome;
         status_ff  <= result.status_code;
         bytes_ff   <= result.header_bytes;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.outcome      = outcome_ff;
   assign rsp_ch.status_code  = status_ff;
   assign rsp_ch.header_bytes = bytes_ff;

endmodule

@@ rtl/http_connect_reply_parser.sv @@
// Top level of the HTTP CONNECT reply parser.
// Instantiates hcrp_in_stage, hcrp_scan and hcrp_out_stage; depends on hcrp_pkg and the
// channel interfaces.
//
//   Channel  Direction  Payload                                  Handshake
//   req_ch   in         kind, rx_byte                            valid / ready
//   rsp_ch   out        outcome, status_code, header_bytes       valid / ready
//   csr_ch   in         header_limit                             valid / ready (always ready)
//
// Each accepted item is held in the input register and then scanned into the result
// register, which offers the result on rsp_ch.
// One item per cycle is accepted while the result side is not stalled (one scan per byte).
// Synchronous reset sets the limit to 8192 and clears the parse state; no clearing pass.
// A stalled result holds the scan, and the input side stalls once its register is full.
module http_connect_reply_parser (
   input  logic        clock,
   input  logic        reset,
   hcrp_req_if.sink    req_ch,
   hcrp_rsp_if.source  rsp_ch,
   hcrp_csr_if.sink    csr_ch
);

   hcrp_pkg::item_type   item;
   hcrp_pkg::result_type result;
   logic                 room;

   // Input register.
   hcrp_in_stage u_in_stage (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .room   (room),
      .item   (item)
   );

   // Parse state and verdict.
   hcrp_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .item   (item),
      .room   (room),
      .result (result)
   );

   // Result register.
   hcrp_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .result (result),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

endmodule
